// File: rtl/b64e_pkg.sv
// package for the streaming base64 encoder: job record, group position codes,
// alphabet lookup and pad character; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

    // bytes already taken of the current three-byte group
    localparam logic [1:0] POS_START = 2'd0;
    localparam logic [1:0] POS_ONE   = 2'd1;
    localparam logic [1:0] POS_TWO   = 2'd2;

    localparam logic [7:0] PAD_CHAR = 8'd61;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one byte worth of output work, built by the front and run by the back
    typedef struct packed {
        logic [5:0] sext0;      // first sextet
        logic [5:0] sext1;      // second sextet, used when two_sext is set
        logic       two_sext;   // two sextets, else one
        logic [1:0] last_idx;   // index of the last character (count minus one)
        logic       last;       // message ends with this job
    } t_job;

    // sextet to ascii, standard alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        priority if (v < 6'd26) return 8'd65 + w;
        else if (v < 6'd52)     return 8'd71 + w;      // 'a' - 26
        else if (v < 6'd62)     return w - 8'd4;       // '0' - 52
        else if (v == 6'd62)    return 8'd43;          // '+'
        else                    return 8'd47;          // '/'
    endfunction

endpackage

`default_nettype wire

// File: rtl/b64e_front.sv
// front part: accepts raw bytes, tracks group position and carried bits,
// and builds one job per byte; depends on b64e_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  [7:0]           i_data_byte,
    input  wire                  i_end_of_message,
    input  wire                  i_queue_full,
    output logic                 o_push,
    output b64e_pkg::t_job       o_job
);
    import b64e_pkg::*;

    logic [1:0] r_pos, n_pos;
    logic [3:0] r_carry, n_carry;

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // classify the byte by group position
    always_comb begin
        o_job.last = i_end_of_message;
        unique case (r_pos)
            POS_ONE: begin
                o_job.sext0    = {r_carry[1:0], i_data_byte[7:4]};
                o_job.sext1    = {i_data_byte[3:0], 2'b00};
                o_job.two_sext = i_end_of_message;
                o_job.last_idx = i_end_of_message ? 2'd2 : 2'd0;
                n_pos          = POS_TWO;
                n_carry        = i_data_byte[3:0];
            end
            POS_TWO: begin
                o_job.sext0    = {r_carry, i_data_byte[7:6]};
                o_job.sext1    = i_data_byte[5:0];
                o_job.two_sext = 1'b1;
                o_job.last_idx = 2'd1;
                n_pos          = POS_START;
                n_carry        = 4'd0;
            end
            default: begin
                // start of a group; an out-of-range position counts as start
                o_job.sext0    = i_data_byte[7:2];
                o_job.sext1    = {i_data_byte[1:0], 4'b0000};
                o_job.two_sext = i_end_of_message;
                o_job.last_idx = i_end_of_message ? 2'd3 : 2'd0;
                n_pos          = POS_ONE;
                n_carry        = {2'b00, i_data_byte[1:0]};
            end
        endcase
    end

    // group state, cleared at message end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_START;
            r_carry <= 4'd0;
        end else if (o_push) begin
            if (i_end_of_message) begin
                r_pos   <= POS_START;
                r_carry <= 4'd0;
            end else begin
                r_pos   <= n_pos;
                r_carry <= n_carry;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/b64e_queue.sv
// short show-ahead job queue between front and back parts; depends on b64e_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  b64e_pkg::t_job       i_job,
    input  wire                  i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output b64e_pkg::t_job       o_job
);
    import b64e_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/b64e_back.sv
// back part: walks the head job one character per cycle, while the output is
// not stalled, into an output register; depends on b64e_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_empty,
    input  b64e_pkg::t_job       i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [7:0]           o_char,
    output logic                 o_final
);
    import b64e_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_final;
    logic       load;
    logic       job_done;
    logic [7:0] n_char;

    assign load     = !i_empty && (!r_valid || i_ready);
    assign job_done = (r_idx == i_job.last_idx);
    assign o_pop    = load && job_done;

    // pick the character at the current index
    always_comb begin
        if (r_idx == 2'd0) begin
            n_char = b64_char(i_job.sext0);
        end else if (r_idx == 2'd1 && i_job.two_sext) begin
            n_char = b64_char(i_job.sext1);
        end else begin
            n_char = PAD_CHAR;
        end
    end

    // character index within the job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (load) begin
            r_idx <= job_done ? 2'd0 : r_idx + 2'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char  <= n_char;
            r_final <= i_job.last && job_done;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_final = r_final;

endmodule

`default_nettype wire

// File: rtl/base64_stream_encoder.sv
// top level of the streaming base64 encoder: front part, job queue, back part
// depends on b64e_pkg, b64e_front, b64e_queue, b64e_back
//
// usage:
//   input stream (s_axis): one raw byte per request in tdata, tlast marks the
//   final byte of a message.
//   output stream (m_axis): one ascii character per request in tdata (base64
//   alphabet or '=' pad), tlast marks the last character of the message.
//   path: a taken byte's job is written into the job queue, and its first
//   character is then registered in the output register before it is valid.
//   throughput: the back part sends one character per cycle while tready is
//   high; a byte gives one to four characters (one or two in a group, up to
//   four with padding at message end), about 4/3 per byte in long messages.
//   the front takes a byte every cycle while the four-entry queue has room.
//   reset: synchronous, active low; clears the group position, carried bits,
//   queue and output valid.
//   stall: when m_axis_tready is low the character holds in the output
//   register, the queue fills, and s_axis_tready drops once it is full.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  wire  [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  wire        i_s_axis_tlast,   // end_of_message
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_char
    output logic       o_m_axis_tlast    // final_char
);
    import b64e_pkg::*;

    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // classify incoming bytes
    b64e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_axis_tvalid),
        .o_ready          (o_s_axis_tready),
        .i_data_byte      (i_s_axis_tdata),
        .i_end_of_message (i_s_axis_tlast),
        .i_queue_full     (full),
        .o_push           (push),
        .o_job            (push_job)
    );

    // decouple front and back
    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (head_job)
    );

    // emit characters
    b64e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_char  (o_m_axis_tdata),
        .o_final (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
